[hw/rtl/shanc_pkg.sv]
package shanc_pkg;

  localparam int MessageBytes = 108;
  localparam int PrefixBytes = MessageBytes - 4;
  localparam int PrefixWords = (PrefixBytes + 3) / 4;
  localparam int WidxW = 5;
  localparam int FifoDepth = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  localparam logic [1:0] REG_MATCH = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_THIGH = 2'd2;
  localparam logic [1:0] REG_TLOW = 2'd3;

  typedef struct packed {
    logic        op;
    logic [4:0]  word_index;
    logic [31:0] word_value;
    logic [31:0] nonce;
  } req_t;

  typedef struct packed {
    logic [31:0]  nonce;
    logic [255:0] h;
  } res_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

[hw/rtl/shanc_front.sv]
// Accepts requests into a short queue that feeds the hash engine.
module shanc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  shanc_pkg::req_t req_in,
  output logic            req_valid,
  input  logic            req_take,
  output shanc_pkg::req_t req_out
);
  shanc_pkg::req_t mem [shanc_pkg::FifoDepth];
  logic            wp;
  logic            rp;
  logic [1:0]      count;

  assign full = (count == 2'(shanc_pkg::FifoDepth));
  assign req_valid = (count != 2'd0);
  assign req_out = mem[rp];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wp] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (req_take && req_valid) rp <= ~rp;
      count <= count + 2'(push && !full) - 2'(req_take && req_valid);
    end
  end
endmodule

[hw/rtl/shanc_engine.sv]
// Executes loads and tests: one compression round per cycle, midstate kept.
module shanc_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_take,
  input  shanc_pkg::req_t req,
  output logic            res_valid,
  input  logic            res_take,
  output shanc_pkg::res_t res
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FIN = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0]   state;
  logic [31:0]  pw [shanc_pkg::PrefixWords];
  logic [31:0]  pw_rd;
  logic [4:0]   rd_idx;
  logic [255:0] mid;
  logic         mid_ready;
  logic         blk2;
  logic [4:0]   fill;
  logic [5:0]   t;
  logic [31:0]  w [16];
  logic [255:0] hs;
  logic [255:0] base;
  logic [31:0]  nonce;

  // Bytes 64..127 of the padded message (block two), as a word source for the fill phase.
  function automatic logic [31:0] tail_word(input logic [4:0] idx, input logic [31:0] pv,
                                             input logic [31:0] nn);
    logic [31:0] r;
    int          bi;
    int          mb;
    r = '0;
    for (int j = 0; j < 4; j++) begin
      bi = 64 + int'(idx) * 4 + j;
      if (bi < shanc_pkg::PrefixBytes) mb = int'(pv[31 - 8 * (bi % 4) -: 8]);
      else if (bi < shanc_pkg::MessageBytes)
        mb = int'(nn[31 - 8 * (bi - shanc_pkg::PrefixBytes) -: 8]);
      else if (bi == shanc_pkg::MessageBytes) mb = 8'h80;
      else if (bi == 126) mb = ((shanc_pkg::MessageBytes * 8) >> 8) & 8'hFF;
      else if (bi == 127) mb = (shanc_pkg::MessageBytes * 8) & 8'hFF;
      else mb = 0;
      r[31 - 8 * j -: 8] = 8'(mb);
    end
    return r;
  endfunction

  logic [31:0] s0w, s1w, wt, wnew;
  logic [31:0] a, b, c, d, e, f, g, hh, t1, t2;
  logic [31:0] fill_word;

  assign wt = w[0];
  always_comb begin
    s0w = shanc_pkg::rotr(w[1], 7) ^ shanc_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    s1w = shanc_pkg::rotr(w[14], 17) ^ shanc_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    wnew = w[0] + s0w + w[9] + s1w;
    {a, b, c, d, e, f, g, hh} = hs;
    t1 = hh + (shanc_pkg::rotr(e, 6) ^ shanc_pkg::rotr(e, 11) ^ shanc_pkg::rotr(e, 25))
       + ((e & f) ^ (~e & g)) + shanc_pkg::round_k(t) + wt;
    t2 = (shanc_pkg::rotr(a, 2) ^ shanc_pkg::rotr(a, 13) ^ shanc_pkg::rotr(a, 22))
       + ((a & b) ^ (a & c) ^ (b & c));
    fill_word = blk2 ? tail_word(fill - 5'd1, pw_rd, nonce) : pw_rd;
  end

  assign req_take = (state == S_IDLE) && req_valid;
  assign res_valid = (state == S_OUT);
  assign res.nonce = nonce;
  assign res.h = hs;

  // Prefix word address: block one reads word fill, block two reads 16+fill, clamped to the last prefix word.
  always_comb begin
    rd_idx = blk2 ? 5'(fill + 5'd16) : fill;
    if (int'(rd_idx) >= shanc_pkg::PrefixWords) rd_idx = 5'(shanc_pkg::PrefixWords - 1);
  end

  always_ff @(posedge clk) begin
    pw_rd <= pw[rd_idx];
    if (req_take && req.op == shanc_pkg::OP_LOAD
        && int'(req.word_index) < shanc_pkg::PrefixWords) begin
      pw[req.word_index] <= req.word_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mid <= '0;
      mid_ready <= 1'b0;
      blk2 <= 1'b0;
      fill <= '0;
      t <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_take) begin
            if (req.op == shanc_pkg::OP_LOAD) begin
              mid_ready <= 1'b0;
            end else begin
              nonce <= req.nonce;
              blk2 <= mid_ready;
              fill <= '0;
              state <= S_FETCH;
            end
          end
        end
        // Read data is registered behind the address, so words arrive at fill-1.
        S_FETCH: begin
          if (fill != 5'd0) begin
            for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
            w[15] <= fill_word;
          end
          if (fill == 5'd16) begin
            base <= blk2 ? mid : shanc_pkg::InitH;
            hs <= blk2 ? mid : shanc_pkg::InitH;
            t <= '0;
            state <= S_ROUND;
          end
          fill <= fill + 5'd1;
        end
        S_ROUND: begin
          hs <= {t1 + t2, a, b, c, d + t1, e, f, g};
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= wnew;
          t <= t + 6'd1;
          if (t == 6'd63) state <= S_FIN;
        end
        S_FIN: begin
          for (int i = 0; i < 8; i++) begin
            hs[255 - 32 * i -: 32] <= hs[255 - 32 * i -: 32] + base[255 - 32 * i -: 32];
          end
          if (blk2) begin
            state <= S_OUT;
          end else begin
            for (int i = 0; i < 8; i++) begin
              mid[255 - 32 * i -: 32] <= hs[255 - 32 * i -: 32] + base[255 - 32 * i -: 32];
            end
            mid_ready <= 1'b1;
            blk2 <= 1'b1;
            fill <= '0;
            state <= S_FETCH;
          end
        end
        S_OUT: begin
          if (res_take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[hw/rtl/shanc_back.sv]
// Result register: judges the digest against the target and holds it for pop.
module shanc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            res_valid,
  output logic            res_take,
  input  shanc_pkg::res_t res,
  input  logic [5:0]      match_digits,
  input  logic [4:0]      digit_limit,
  input  logic [127:0]    target,
  output logic            empty,
  input  logic            pop,
  output logic [31:0]     nonce_out,
  output logic            is_share,
  output logic [63:0]     digest_head,
  output logic [63:0]     digest_next
);
  logic [127:0] dg;
  logic [5:0]   n;
  logic         share;
  logic         eq;
  logic [3:0]   nib;

  assign dg = res.h[255:128];
  assign res_take = res_valid && empty;

  always_comb begin
    n = (match_digits > 6'd32) ? 6'd32 : match_digits;
    eq = 1'b1;
    for (int i = 0; i < 32; i++) begin
      if (6'(i) < n && dg[127 - 4 * i -: 4] != target[127 - 4 * i -: 4]) eq = 1'b0;
    end
    nib = dg[127 - 4 * int'(n[4:0]) -: 4];
    share = eq;
    if (digit_limit < 5'd16) begin
      if (n[5]) share = 1'b0;
      else if ({1'b0, nib} >= digit_limit) share = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      empty <= 1'b1;
    end else if (res_take) begin
      empty <= 1'b0;
    end else if (pop) begin
      empty <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      nonce_out <= res.nonce;
      is_share <= share;
      digest_head <= dg[127:64];
      digest_next <= dg[63:0];
    end
  end
endmodule

[hw/rtl/sha256_nonce_share_checker.sv]
// SHA-256 nonce share checker. Push loads prefix words (op 0, no result) or
// tests a nonce (op 1, one result). A test passes through the request queue,
// the fetch of 16 words through a registered read, 64 rounds of a single
// round unit, a finish step and the move into the result register. The
// engine takes a new test only after the previous result has left it. The
// first test after any load also computes the midstate, running the fetch,
// rounds and finish once more for the first block. A load leaves the engine
// in its idle state. A two-entry request queue takes pushes while the engine
// works; one result register holds a result until popped, and the engine
// waits while it is occupied.
module sha256_nonce_share_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        op,
  input  logic [4:0]  word_index,
  input  logic [31:0] word_value,
  input  logic [31:0] nonce,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] nonce_out,
  output logic        is_share,
  output logic [63:0] digest_head,
  output logic [63:0] digest_next,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  shanc_pkg::req_t req_in, req_q;
  shanc_pkg::res_t res;
  logic            req_valid, req_take, res_valid, res_take;
  logic [5:0]      match_digits;
  logic [4:0]      digit_limit;
  logic [127:0]    target;

  assign req_in = '{op: op, word_index: word_index, word_value: word_value, nonce: nonce};
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_digits <= '0;
      digit_limit <= 5'd16;
      target <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        shanc_pkg::REG_MATCH: match_digits <= cfg_data[5:0];
        shanc_pkg::REG_LIMIT: digit_limit <= cfg_data[4:0];
        shanc_pkg::REG_THIGH: target[127:64] <= cfg_data;
        shanc_pkg::REG_TLOW: target[63:0] <= cfg_data;
        default: ;
      endcase
    end
  end

  shanc_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .req_in(req_in),
    .req_valid(req_valid), .req_take(req_take), .req_out(req_q));

  shanc_engine u_engine (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_take(req_take), .req(req_q),
    .res_valid(res_valid), .res_take(res_take), .res(res));

  shanc_back u_back (
    .clk(clk), .rst(rst), .res_valid(res_valid), .res_take(res_take), .res(res),
    .match_digits(match_digits), .digit_limit(digit_limit), .target(target),
    .empty(empty), .pop(pop), .nonce_out(nonce_out), .is_share(is_share),
    .digest_head(digest_head), .digest_next(digest_next));
endmodule

[tb/sv/digest_share_monitor.sv]
`timescale 1ns / 100ps

module digest_share_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic        op,
  input  logic [4:0]  word_index,
  input  logic [31:0] word_value,
  input  logic [31:0] nonce,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] nonce_out,
  input  logic        is_share,
  input  logic [63:0] digest_head,
  input  logic [63:0] digest_next,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          tests_seen,
  output int          shares_seen,
  output int          loads_seen,
  output logic [63:0] last_head,
  output logic [63:0] last_next
);

  typedef struct packed {
    logic [31:0] nonce;
    logic        share;
    logic [63:0] head;
    logic [63:0] next;
  } digest_rec_t;

  localparam logic [64*32-1:0] RoundConst = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [255:0] StartHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic [5:0]  match_q;
  logic [4:0]  limit_q;
  logic [63:0] thigh_q;
  logic [63:0] tlow_q;
  logic [31:0] prefix_mem [shanc_pkg::PrefixWords];
  logic [255:0] mid_q;
  logic         mid_ok;
  digest_rec_t  digest_q [$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] compress_block(input logic [255:0] hin,
                                                  input logic [511:0] blk);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++) w[t] = blk[511-32*t -: 32];
    for (int t = 16; t < 64; t++) begin
      s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    {a, b, c, d, e, f, g, hh} = hin;
    for (int t = 0; t < 64; t++) begin
      s1 = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
      t1 = hh + s1 + ((e & f) ^ (~e & g)) + RoundConst[2047-32*t -: 32] + w[t];
      s0 = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
      t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    return {hin[255:224] + a, hin[223:192] + b, hin[191:160] + c, hin[159:128] + d,
            hin[127:96] + e, hin[95:64] + f, hin[63:32] + g, hin[31:0] + hh};
  endfunction

  function automatic logic share_rule(input logic [127:0] dig, input logic [127:0] tgt,
                                      input logic [5:0] md, input logic [4:0] lim);
    int n;
    logic ok;
    n = (md > 32) ? 32 : md;
    ok = 1'b1;
    for (int i = 0; i < n; i++)
      if (dig[127-4*i -: 4] != tgt[127-4*i -: 4]) ok = 1'b0;
    // With every digit matched there is no following digit to test.
    if (lim < 16) begin
      if (n >= 32) ok = 1'b0;
      else if (dig[127-4*n -: 4] >= lim) ok = 1'b0;
    end
    return ok;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    logic [511:0] blk;
    logic [255:0] mid, h;
    digest_rec_t  rec, exp_rec;
    if (rst) begin
      match_q <= '0;
      limit_q <= 5'd16;
      thigh_q <= '0;
      tlow_q <= '0;
      mid_ok <= 1'b0;
      digest_q.delete();
      pending <= 0;
      tests_seen <= 0;
      shares_seen <= 0;
      loads_seen <= 0;
      last_head <= '0;
      last_next <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          shanc_pkg::REG_MATCH: match_q <= cfg_data[5:0];
          shanc_pkg::REG_LIMIT: limit_q <= cfg_data[4:0];
          shanc_pkg::REG_THIGH: thigh_q <= cfg_data;
          shanc_pkg::REG_TLOW:  tlow_q <= cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        if (op == shanc_pkg::OP_LOAD) begin
          if (word_index < shanc_pkg::PrefixWords) prefix_mem[word_index] = word_value;
          mid_ok <= 1'b0;
          loads_seen <= loads_seen + 1;
        end else begin
          mid = mid_q;
          if (!mid_ok) begin
            for (int i = 0; i < 16; i++) blk[511-32*i -: 32] = prefix_mem[i];
            mid = compress_block(StartHash, blk);
            mid_q <= mid;
            mid_ok <= 1'b1;
          end
          blk = '0;
          for (int i = 0; i < shanc_pkg::PrefixWords - 16; i++)
            blk[511-32*i -: 32] = prefix_mem[16+i];
          blk[511-32*10 -: 32] = nonce;
          blk[511-32*11 -: 32] = 32'h8000_0000;
          blk[31:0] = 32'(shanc_pkg::MessageBytes * 8);
          h = compress_block(mid, blk);
          rec.nonce = nonce;
          rec.head = h[255:192];
          rec.next = h[191:128];
          rec.share = share_rule(h[255:128], {thigh_q, tlow_q}, match_q, limit_q);
          digest_q.push_back(rec);
          last_head <= rec.head;
          last_next <= rec.next;
          tests_seen <= tests_seen + 1;
          if (rec.share) shares_seen <= shares_seen + 1;
        end
      end
      if (pop && !empty) begin
        if (digest_q.size() == 0) begin
          report("unexpected result, nonce", {32'd0, nonce_out}, '0);
        end else begin
          exp_rec = digest_q.pop_front();
          if (nonce_out !== exp_rec.nonce)
            report("nonce_out", 64'(nonce_out), 64'(exp_rec.nonce));
          if (is_share !== exp_rec.share)
            report("is_share", 64'(is_share), 64'(exp_rec.share));
          if (digest_head !== exp_rec.head) report("digest_head", digest_head, exp_rec.head);
          if (digest_next !== exp_rec.next) report("digest_next", digest_next, exp_rec.next);
        end
      end
      pending <= digest_q.size();
    end
  end

endmodule

[tb/sv/tb_sha256_nonce_share_checker.sv]
`timescale 1ns / 100ps

module tb_sha256_nonce_share_checker;

  localparam int CycleLimit = 2000000;
  localparam int SettleCycles = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic op = shanc_pkg::OP_LOAD;
  logic [4:0] word_index = '0;
  logic [31:0] word_value = '0;
  logic [31:0] nonce = '0;
  logic empty;
  logic pop = 1'b0;
  logic [31:0] nonce_out;
  logic is_share;
  logic [63:0] digest_head;
  logic [63:0] digest_next;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = shanc_pkg::REG_MATCH;
  logic [63:0] cfg_data = '0;

  int errors, pending, tests_seen, shares_seen, loads_seen;
  logic [63:0] last_head, last_next;
  logic quiet = 1'b0;
  int pop_idle = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  sha256_nonce_share_checker uut (.*);

  digest_share_monitor mon (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: mostly ready, with short random stalls.
  always @(posedge clk) begin
    if (rst || quiet) begin
      pop <= !rst;
    end else if (pop_idle > 0) begin
      pop <= 1'b0;
      pop_idle <= pop_idle - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      pop <= 1'b0;
      pop_idle <= $urandom_range(0, 2);
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic send(input logic o, input logic [4:0] idx, input logic [31:0] val,
                      input logic [31:0] nc);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push <= 1'b1;
    op <= o;
    word_index <= idx;
    word_value <= val;
    nonce <= nc;
    do @(posedge clk); while (full);
  endtask

  task automatic load_all_words();
    for (int i = 0; i < shanc_pkg::PrefixWords; i++)
      send(shanc_pkg::OP_LOAD, 5'(i), $urandom, $urandom);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Loads leave no result behind, so give the engine time to drain them.
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_rule(input logic [5:0] md, input logic [4:0] lim,
                          input logic [63:0] th, input logic [63:0] tl);
    write_reg(shanc_pkg::REG_MATCH, 64'(md));
    write_reg(shanc_pkg::REG_LIMIT, 64'(lim));
    write_reg(shanc_pkg::REG_THIGH, th);
    write_reg(shanc_pkg::REG_TLOW, tl);
  endtask

  initial begin
    logic [31:0] nc;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: every word written before any test reads it.
    for (int i = 0; i < shanc_pkg::PrefixWords; i++)
      send(shanc_pkg::OP_LOAD, 5'(i), (i % 2) ? 32'hffff_ffff : 32'h0, 32'h0);
    send(shanc_pkg::OP_TEST, 5'd0, 32'h0, 32'h0000_0000);
    send(shanc_pkg::OP_TEST, 5'd31, 32'hffff_ffff, 32'hffff_ffff);
    send(shanc_pkg::OP_LOAD, 5'd26, 32'hdead_beef, 32'h0);
    send(shanc_pkg::OP_LOAD, 5'd31, 32'hffff_ffff, 32'h0);
    send(shanc_pkg::OP_TEST, 5'd0, 32'h0, 32'h1234_5678);
    send(shanc_pkg::OP_LOAD, 5'd25, 32'h0, 32'h0);
    send(shanc_pkg::OP_TEST, 5'd0, 32'h0, 32'h8000_0001);
    nc = 32'hcafe_f00d;
    send(shanc_pkg::OP_TEST, 5'd0, 32'h0, nc);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Full-length match against the digest just seen, then the rule variants.
    set_rule(6'd32, 5'd16, last_head, last_next);
    send(shanc_pkg::OP_TEST, 5'd0, 32'h0, nc);
    set_rule(6'd63, 5'd16, last_head, last_next);
    send(shanc_pkg::OP_TEST, 5'd0, 32'h0, nc);
    set_rule(6'd32, 5'd15, last_head, last_next);
    send(shanc_pkg::OP_TEST, 5'd0, 32'h0, nc);
    set_rule(6'd16, 5'd0, last_head, last_next);
    send(shanc_pkg::OP_TEST, 5'd0, 32'h0, nc);
    set_rule(6'd16, 5'd31, last_head, last_next);
    send(shanc_pkg::OP_TEST, 5'd0, 32'h0, nc);
    set_rule(6'd0, 5'd8, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    send(shanc_pkg::OP_TEST, 5'd0, 32'h0, nc);

    // Random phases, each under its own rule; the last one runs without stalls.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: set_rule(6'($urandom_range(0, 2)), 5'($urandom_range(1, 15)),
                    last_head, last_next);
        1: set_rule(6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)),
                    {$urandom, $urandom}, {$urandom, $urandom});
        2: set_rule(6'd0, 5'($urandom_range(4, 12)), 64'h0, 64'h0);
        default: set_rule(6'd1, 5'd16, last_head, last_next);
      endcase
      quiet = (ph == 7);
      if ($urandom_range(0, 1)) load_all_words();
      for (int k = 0; k < 200; k++) begin
        if ($urandom_range(0, 99) < 12)
          send(shanc_pkg::OP_LOAD, 5'($urandom_range(0, 31)), $urandom, $urandom);
        else
          send(shanc_pkg::OP_TEST, 5'($urandom_range(0, 31)), $urandom, $urandom);
      end
    end
    push <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    $display("Covered %0d nonce tests (%0d shares) and %0d prefix loads",
             tests_seen, shares_seen, loads_seen);
    $display("under several match and limit rules, including full-length and disabled checks");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
